>>> rtl/core/assert_macros.svh
// Assertion macros used by the timer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The expression must hold at every clock edge out of reset.
`define ITR_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ITR_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ITR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ITR_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ITR_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ITR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/core/itr_pkg.sv
// Shared types and constants of the interval timer with periodic reload.
package itr_pkg;

    localparam int SEC_W  = 27;
    localparam int USEC_W = 20;

    localparam logic [20:0]      USEC_PER_SEC = 21'd1000000;
    localparam logic [USEC_W-1:0] MAX_MICROS  = 20'd999999;
    localparam logic [SEC_W-1:0]  MAX_SECONDS = 27'd100000000;
    localparam logic [USEC_W-1:0] TICK_RESET  = 20'd10000;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam int ADDR_W    = 4;
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_RELOAD_SEC  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_RELOAD_USEC = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_TICK_USEC   = 2'd2;

    localparam int CMD_QUEUE_DEPTH = 2;

    // Configuration as the datapath sees it, already clamped to range.
    typedef struct packed {
        logic [SEC_W-1:0]  reload_sec;
        logic [USEC_W-1:0] reload_usec;
        logic [USEC_W-1:0] tick_usec;
    } cfg_t;

    // Classified word handed from the front end to the back end.
    typedef struct packed {
        logic              op;
        logic              bad;
        logic [SEC_W-1:0]  sec;
        logic [USEC_W-1:0] usec;
    } cmd_t;

    typedef struct packed {
        logic [SEC_W-1:0]  left_sec;
        logic [USEC_W-1:0] left_usec;
        logic              expired;
        logic              running;
        logic              bad_load;
    } result_t;

endpackage

>>> rtl/core/itr_regs.sv
// Configuration registers behind the APB-style port.
module itr_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [itr_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output itr_pkg::cfg_t               cfg
);
    import itr_pkg::*;

    logic [SEC_W-1:0]     reload_sec_reg;
    logic [USEC_W-1:0]    reload_usec_reg;
    logic [USEC_W-1:0]    tick_usec_reg;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_sec_reg  <= '0;
            reload_usec_reg <= '0;
            tick_usec_reg   <= TICK_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_RELOAD_SEC:  reload_sec_reg  <= pwdata[SEC_W-1:0];
                REG_RELOAD_USEC: reload_usec_reg <= pwdata[USEC_W-1:0];
                REG_TICK_USEC:   tick_usec_reg   <= pwdata[USEC_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_RELOAD_SEC:  prdata = 32'(reload_sec_reg);
            REG_RELOAD_USEC: prdata = 32'(reload_usec_reg);
            REG_TICK_USEC:   prdata = 32'(tick_usec_reg);
            default:         prdata = '0;
        endcase
    end

    // Out-of-range settings behave as the nearest legal value.
    always_comb
    begin
        cfg.reload_sec  = (reload_sec_reg > MAX_SECONDS) ? MAX_SECONDS : reload_sec_reg;
        cfg.reload_usec = (reload_usec_reg > MAX_MICROS) ? MAX_MICROS : reload_usec_reg;
        cfg.tick_usec   = (tick_usec_reg > MAX_MICROS) ? MAX_MICROS : tick_usec_reg;
    end

endmodule

>>> rtl/core/itr_front.sv
// Front end: validates and rounds loads, clamps tick lengths.
module itr_front (
    input  logic                       op,
    input  logic signed [31:0]         load_seconds,
    input  logic signed [31:0]         load_micros,
    input  logic [itr_pkg::USEC_W-1:0] elapsed_micros,
    input  itr_pkg::cfg_t              cfg,
    output itr_pkg::cmd_t              cmd
);
    import itr_pkg::*;

    logic [31:0]       s_u;
    logic [31:0]       m_u;
    logic              invalid;
    logic [USEC_W-1:0] load_m;
    logic [USEC_W-1:0] elapsed_c;

    assign s_u = $unsigned(load_seconds);
    assign m_u = $unsigned(load_micros);

    // A negative value has its top bit set and so fails the upper bound too.
    assign invalid = (s_u > 32'(MAX_SECONDS)) || (m_u > 32'(MAX_MICROS));

    always_comb
    begin
        load_m = m_u[USEC_W-1:0];
        if ((s_u == 32'd0) && (load_m != '0) && (load_m < cfg.tick_usec))
        begin
            load_m = cfg.tick_usec;
        end
        elapsed_c = (elapsed_micros > MAX_MICROS) ? MAX_MICROS : elapsed_micros;
    end

    always_comb
    begin
        cmd.op  = op;
        cmd.bad = (op == OP_LOAD) && invalid;
        cmd.sec = s_u[SEC_W-1:0];
        cmd.usec = (op == OP_TICK) ? elapsed_c : load_m;
    end

endmodule

>>> rtl/core/itr_cmd_queue.sv
// Short queue of classified words between the front and back ends.
module itr_cmd_queue #(
    parameter int DEPTH = itr_pkg::CMD_QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  itr_pkg::cmd_t push_word,
    output logic          full,
    input  logic          pop,
    output itr_pkg::cmd_t head,
    output logic          empty
);
    import itr_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg;
    logic [IDX_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/itr_back.sv
// Back end: countdown state, expiry and reload, and the result buffer.
`include "assert_macros.svh"

module itr_back (
    input  logic            clk,
    input  logic            rst_n,
    input  itr_pkg::cfg_t   cfg,
    input  itr_pkg::cmd_t   cmd,
    input  logic            cmd_empty,
    output logic            cmd_pop,
    input  logic            out_pop,
    output logic            out_empty,
    output itr_pkg::result_t out_word
);
    import itr_pkg::*;

    logic [SEC_W-1:0]  cs_reg;
    logic [USEC_W-1:0] cm_reg;
    logic [SEC_W-1:0]  cs_next;
    logic [USEC_W-1:0] cm_next;
    logic              expired;

    result_t           out_mem [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        out_cnt_reg;
    logic              out_take;
    logic              room;

    logic              nz;
    logic [USEC_W-1:0] over;
    logic [20:0]       borrow_sum;
    logic [20:0]       reload_sum;
    result_t           res;

    assign out_empty = (out_cnt_reg == 2'd0);
    assign out_take  = out_pop && !out_empty;
    assign room      = (out_cnt_reg != 2'd2) || out_take;
    assign cmd_pop   = !cmd_empty && room;
    assign out_word  = out_mem[rd_ptr_reg];

    assign nz         = (cs_reg != '0) || (cm_reg != '0);
    assign over       = cmd.usec - cm_reg;
    assign borrow_sum = {1'b0, cm_reg} + USEC_PER_SEC - {1'b0, cmd.usec};
    assign reload_sum = {1'b0, cfg.reload_usec} + USEC_PER_SEC - {1'b0, over};

    always_comb
    begin
        cs_next = cs_reg;
        cm_next = cm_reg;
        expired = 1'b0;
        if (cmd.op == OP_LOAD)
        begin
            if (!cmd.bad)
            begin
                cs_next = cmd.sec;
                cm_next = cmd.usec;
            end
        end
        else if (nz)
        begin
            if ((cs_reg == '0) && (cm_reg <= cmd.usec))
            begin
                // Expiry: reload less overshoot, or 1 us; none: stop.
                expired = 1'b1;
                if ((cfg.reload_sec == '0) && (cfg.reload_usec == '0))
                begin
                    cs_next = '0;
                    cm_next = '0;
                end
                else if (cfg.reload_usec >= over)
                begin
                    cs_next = cfg.reload_sec;
                    cm_next = cfg.reload_usec - over;
                end
                else if (cfg.reload_sec == '0)
                begin
                    cs_next = '0;
                    cm_next = USEC_W'(1);
                end
                else
                begin
                    cs_next = cfg.reload_sec - 1'b1;
                    cm_next = reload_sum[USEC_W-1:0];
                end
            end
            else if (cm_reg < cmd.usec)
            begin
                cs_next = cs_reg - 1'b1;
                cm_next = borrow_sum[USEC_W-1:0];
            end
            else
            begin
                cm_next = cm_reg - cmd.usec;
            end
        end
    end

    always_comb
    begin
        res.left_sec  = cs_next;
        res.left_usec = cm_next;
        res.expired   = expired;
        res.running   = (cs_next != '0) || (cm_next != '0);
        res.bad_load  = cmd.bad;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            out_mem[wr_ptr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs_reg      <= '0;
            cm_reg      <= '0;
            wr_ptr_reg  <= 1'b0;
            rd_ptr_reg  <= 1'b0;
            out_cnt_reg <= 2'd0;
        end
        else
        begin
            if (cmd_pop)
            begin
                cs_reg     <= cs_next;
                cm_reg     <= cm_next;
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (out_take)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (cmd_pop && !out_take)
            begin
                out_cnt_reg <= out_cnt_reg + 1'b1;
            end
            else if (out_take && !cmd_pop)
            begin
                out_cnt_reg <= out_cnt_reg - 1'b1;
            end
        end
    end

    `ITR_ASSERT_ALWAYS(a_usec_range, clk, rst_n, cm_reg <= MAX_MICROS, "micros above range")
    `ITR_ASSERT_ALWAYS(a_sec_range, clk, rst_n, cs_reg <= MAX_SECONDS, "seconds above range")
    `ITR_ASSERT_NEXT(a_idle_hold, clk, rst_n, !cmd_pop, $stable(cs_reg) && $stable(cm_reg), "state moved with no word taken")
    `ITR_ASSERT_NEXT(a_bad_hold, clk, rst_n, cmd_pop && cmd.bad, $stable(cs_reg) && $stable(cm_reg), "rejected load changed the state")
    `ITR_ASSERT_IMPLIES(a_no_overflow, clk, rst_n, (out_cnt_reg == 2'd2) && !out_take, !cmd_pop, "result buffer overrun")

endmodule

>>> rtl/core/interval_timer_reload_core.sv
// Interval countdown timer with periodic reload: top level.
//
// Words enter on push/full: a word is taken at a clock edge with push high
// and full low. op selects a load (check and install a seconds/microseconds
// value) or a tick (count down by elapsed_micros, reloading on expiry).
// Every word yields exactly one result word, held on the result ports while
// empty is low and taken at an edge with pop high.
// A word accepted into the command queue waits at its head until the back
// end takes it, which needs room in the result buffer; at that edge the
// back end updates the countdown and writes the result buffer, from which
// the result is popped. Throughput is one word per cycle while pop is
// kept high; the countdown subtract and reload in the back end are
// combinational. When pop stays low the two-entry result buffer and the
// two-entry command queue fill and full rises; nothing is dropped, and
// full falls just after the first edge at which a result is taken again.
// Reset clears the countdown to zero, empties both queues and sets the
// registers to no reload interval and a 10000 us tick. Registers sit at
// byte addresses 0, 4 and 8; the user must see that they are written only
// while the timer is idle, as the block itself does not enforce this.
module interval_timer_reload_core #(
    parameter int CMD_DEPTH = itr_pkg::CMD_QUEUE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [itr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       push,
    output logic                       full,
    input  logic                       op,
    input  logic signed [31:0]         load_seconds,
    input  logic signed [31:0]         load_micros,
    input  logic [itr_pkg::USEC_W-1:0] elapsed_micros,
    output logic                       empty,
    input  logic                       pop,
    output logic [itr_pkg::SEC_W-1:0]  left_seconds,
    output logic [itr_pkg::USEC_W-1:0] left_micros,
    output logic                       expired,
    output logic                       running,
    output logic                       bad_load
);
    import itr_pkg::*;

    cfg_t    cfg;
    cmd_t    front_word;
    cmd_t    head_word;
    logic    q_empty;
    logic    q_pop;
    result_t res;

    itr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    itr_front u_front (
        .op             (op),
        .load_seconds   (load_seconds),
        .load_micros    (load_micros),
        .elapsed_micros (elapsed_micros),
        .cfg            (cfg),
        .cmd            (front_word)
    );

    itr_cmd_queue #(
        .DEPTH (CMD_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (front_word),
        .full      (full),
        .pop       (q_pop),
        .head      (head_word),
        .empty     (q_empty)
    );

    itr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (head_word),
        .cmd_empty (q_empty),
        .cmd_pop   (q_pop),
        .out_pop   (pop),
        .out_empty (empty),
        .out_word  (res)
    );

    assign left_seconds = res.left_sec;
    assign left_micros  = res.left_usec;
    assign expired      = res.expired;
    assign running      = res.running;
    assign bad_load     = res.bad_load;

endmodule

>>> verif/interval_timer_reload_core_tb.sv
// Self-checking testbench for the interval countdown timer with periodic reload.
module interval_timer_reload_core_tb;

    import itr_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASE_WORDS    = 210;

    // Tracks the countdown value and registers, and holds the result words still owed.
    class countdown_scoreboard;
        logic [SEC_W-1:0]  rl_sec;
        logic [USEC_W-1:0] rl_usec;
        logic [USEC_W-1:0] tick_usec;
        logic [SEC_W-1:0]  cnt_sec;
        logic [USEC_W-1:0] cnt_usec;
        result_t           awaited_results[$];
        int unsigned       mismatches;

        function new();
            rl_sec     = '0;
            rl_usec    = '0;
            tick_usec  = TICK_RESET;
            cnt_sec    = '0;
            cnt_usec   = '0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
            case (idx)
                REG_RELOAD_SEC:  rl_sec = value[SEC_W-1:0];
                REG_RELOAD_USEC: rl_usec = value[USEC_W-1:0];
                REG_TICK_USEC:   tick_usec = value[USEC_W-1:0];
                default: ;
            endcase
        endfunction

        // Installs the next period, shortened by the overshoot so the timer does not drift.
        function void reload_interval(int unsigned over);
            int unsigned rs;
            int unsigned rm;
            rs = (rl_sec > MAX_SECONDS) ? 32'(MAX_SECONDS) : 32'(rl_sec);
            rm = (rl_usec > MAX_MICROS) ? 32'(MAX_MICROS) : 32'(rl_usec);
            if (rs == 0 && rm == 0) begin
                cnt_sec  = '0;
                cnt_usec = '0;
            end else if (rm >= over) begin
                cnt_sec  = SEC_W'(rs);
                cnt_usec = USEC_W'(rm - over);
            end else if (rs == 0) begin
                cnt_sec  = '0;
                cnt_usec = USEC_W'(1);
            end else begin
                cnt_sec  = SEC_W'(rs - 1);
                cnt_usec = USEC_W'(rm + USEC_PER_SEC - over);
            end
        endfunction

        function void note_word(logic op_w, logic [31:0] sec_w, logic [31:0] usec_w,
                                logic [USEC_W-1:0] el_w);
            int unsigned t;
            int unsigned m;
            int unsigned e;
            result_t     r;
            r = '0;
            if (op_w == OP_LOAD) begin
                if (sec_w > MAX_SECONDS || usec_w > MAX_MICROS) begin
                    r.bad_load = 1'b1;
                end else begin
                    t = (tick_usec > MAX_MICROS) ? 32'(MAX_MICROS) : 32'(tick_usec);
                    m = usec_w;
                    if (sec_w == 0 && m != 0 && m < t)
                        m = t;
                    cnt_sec  = sec_w[SEC_W-1:0];
                    cnt_usec = USEC_W'(m);
                end
            end else if (cnt_sec != 0 || cnt_usec != 0) begin
                e = (el_w > MAX_MICROS) ? 32'(MAX_MICROS) : 32'(el_w);
                if (cnt_usec < e) begin
                    if (cnt_sec == 0) begin
                        r.expired = 1'b1;
                        reload_interval(e - cnt_usec);
                    end else begin
                        cnt_usec = USEC_W'(cnt_usec + USEC_PER_SEC - e);
                        cnt_sec  = SEC_W'(cnt_sec - 1);
                    end
                end else begin
                    cnt_usec = USEC_W'(cnt_usec - e);
                    if (cnt_sec == 0 && cnt_usec == 0) begin
                        r.expired = 1'b1;
                        reload_interval(0);
                    end
                end
            end
            r.left_sec  = cnt_sec;
            r.left_usec = cnt_usec;
            r.running   = (cnt_sec != 0 || cnt_usec != 0);
            awaited_results.push_back(r);
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_word(result_t got);
            result_t want;
            if (awaited_results.size() == 0) begin
                $display("%0t: result word with nothing expected: expected none, actual %0d s %0d us",
                         $time, got.left_sec, got.left_usec);
                mismatches++;
                return;
            end
            want = awaited_results.pop_front();
            compare_field("left_seconds", want.left_sec, got.left_sec);
            compare_field("left_micros", want.left_usec, got.left_usec);
            compare_field("expired", want.expired, got.expired);
            compare_field("running", want.running, got.running);
            compare_field("bad_load", want.bad_load, got.bad_load);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  push;
    logic                  full;
    logic                  op;
    logic signed [31:0]    load_seconds;
    logic signed [31:0]    load_micros;
    logic [USEC_W-1:0]     elapsed_micros;
    logic                  empty;
    logic                  pop;
    logic [SEC_W-1:0]      left_seconds;
    logic [USEC_W-1:0]     left_micros;
    logic                  expired;
    logic                  running;
    logic                  bad_load;

    countdown_scoreboard sb = new();
    bit                  calm = 1'b0;
    int                  gap_pct = 10;
    int                  idle_cycles = 0;

    interval_timer_reload_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .push           (push),
        .full           (full),
        .op             (op),
        .load_seconds   (load_seconds),
        .load_micros    (load_micros),
        .elapsed_micros (elapsed_micros),
        .empty          (empty),
        .pop            (pop),
        .left_seconds   (left_seconds),
        .left_micros    (left_micros),
        .expired        (expired),
        .running        (running),
        .bad_load       (bad_load)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_word(input logic op_w, input logic [31:0] sec_w,
                             input logic [31:0] usec_w, input logic [USEC_W-1:0] el_w);
        if (!calm && $urandom_range(0, 99) < gap_pct)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        push           <= 1'b1;
        op             <= op_w;
        load_seconds   <= sec_w;
        load_micros    <= usec_w;
        elapsed_micros <= el_w;
        @(posedge clk);
        while (full) @(posedge clk);
        sb.note_word(op_w, sec_w, usec_w, el_w);
    endtask

    // The unused fields of each word carry random bits so that the block must ignore them.
    task automatic send_load(input logic [31:0] sec_w, input logic [31:0] usec_w);
        send_word(OP_LOAD, sec_w, usec_w, USEC_W'($urandom_range(0, 20'hFFFFF)));
    endtask

    task automatic send_tick(input logic [USEC_W-1:0] el_w);
        send_word(OP_TICK, $urandom, $urandom, el_w);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (sb.awaited_results.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        sb.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [31:0] sec_w, input logic [31:0] usec_w,
                             input logic [31:0] tick_w);
        drain();
        write_reg(REG_RELOAD_SEC, sec_w);
        write_reg(REG_RELOAD_USEC, usec_w);
        write_reg(REG_TICK_USEC, tick_w);
    endtask

    function automatic logic [31:0] pick_seconds();
        case ($urandom_range(0, 9))
            6, 7: return $urandom_range(1, 3);
            8: return 32'(MAX_SECONDS);
            9: return $urandom_range(0, MAX_SECONDS);
            default: return 0;
        endcase
    endfunction

    function automatic logic [31:0] pick_micros();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 32'(MAX_MICROS);
            2, 3: return $urandom_range(1, 20000);
            default: return $urandom_range(0, MAX_MICROS);
        endcase
    endfunction

    // Some ticks land the count exactly on zero, or overshoot by exactly the microseconds of the reload interval.
    function automatic logic [USEC_W-1:0] pick_elapsed();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return USEC_W'($urandom_range(1, 1000));
            2: return USEC_W'($urandom_range(0, 20'hFFFFF));
            3: if (sb.cnt_sec == 0) return sb.cnt_usec;
            4: if (sb.cnt_sec == 0 && ({1'b0, sb.cnt_usec} + sb.rl_usec) <= MAX_MICROS)
                   return USEC_W'({1'b0, sb.cnt_usec} + sb.rl_usec);
            default: ;
        endcase
        return USEC_W'($urandom_range(0, MAX_MICROS));
    endfunction

    task automatic run_random(input int unsigned count);
        int unsigned sent;
        int unsigned n_ticks;
        sent = 0;
        while (sent < count)
        begin
            case ($urandom_range(0, 9))
                0: send_load($urandom, $urandom);
                1: send_tick(USEC_W'($urandom_range(0, 20'hFFFFF)));
                default:
                begin
                    send_load(pick_seconds(), pick_micros());
                    n_ticks = $urandom_range(1, 12);
                    repeat (n_ticks) send_tick(pick_elapsed());
                    sent += n_ticks;
                end
            endcase
            sent++;
        end
    endtask

    // Result side: pop stalls in bursts whose frequency wanders through the run.
    initial
    begin
        int stall_pct;
        stall_pct = 10;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 199) == 0)
                stall_pct = $urandom_range(0, 3) * 8;
            if (!calm && $urandom_range(0, 99) < stall_pct)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                sb.check_word({left_seconds, left_micros, expired, running, bad_load});
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("interval_timer_reload_core_tb: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int phase;
        rst_n          <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        push           <= 1'b0;
        op             <= OP_LOAD;
        load_seconds   <= '0;
        load_micros    <= '0;
        elapsed_micros <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // One-shot behaviour with the reset registers.
        send_tick(20'd5);
        send_load(0, 0);
        send_load(32'hFFFFFFFF, 0);
        send_load(0, 32'hFFFFFFFF);
        send_load(MAX_SECONDS + 1, 0);
        send_load(0, 1000000);
        send_load(32'h7FFFFFFF, 32'h80000000);
        send_load(32'(MAX_SECONDS), 32'(MAX_MICROS));
        send_tick(20'hFFFFF);
        send_tick(20'd0);
        send_load(0, 1);
        send_tick(20'd10000);
        send_tick(20'd3);
        send_load(0, 20000);
        send_tick(20'd30000);
        send_load(1, 0);
        send_tick(20'd1);

        // Sub-second period with rounding disabled.
        configure(0, 5000, 0);
        send_load(0, 1);
        send_tick(20'd5001);
        send_load(0, 100);
        send_tick(20'd100);
        send_tick(20'd999999);
        send_tick(20'd1);

        // Period with whole seconds, borrowing after the reload.
        configure(2, 100, 32'(MAX_MICROS));
        send_load(0, 500);
        send_tick(20'd999999);
        send_tick(20'd300000);

        for (phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: configure(0, 0, $urandom_range(1, MAX_MICROS));
                1: configure(0, $urandom_range(1, 50000), 1);
                2: configure(1, 500000, 0);
                3: configure(32'(MAX_SECONDS), 32'(MAX_MICROS), 32'(MAX_MICROS));
                4: configure(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
                5: configure(0, 1, 32'h000FFFFF);
                default: configure($urandom_range(0, 3), $urandom_range(0, MAX_MICROS),
                                   $urandom_range(0, MAX_MICROS));
            endcase
            gap_pct = (phase == 2) ? 0 : $urandom_range(3, 25);
            if (phase == 7)
                calm = 1'b1;
            run_random(PHASE_WORDS);
        end

        drain();
        if (sb.mismatches == 0 && sb.awaited_results.size() == 0)
            $display("interval_timer_reload_core_tb: PASS");
        else
            $display("interval_timer_reload_core_tb: FAIL");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/itr_pkg.sv
rtl/core/itr_regs.sv
rtl/core/itr_front.sv
rtl/core/itr_cmd_queue.sv
rtl/core/itr_back.sv
rtl/core/interval_timer_reload_core.sv
verif/interval_timer_reload_core_tb.sv
